@@ sv/tfn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_pkg: shared types and constants
// Fixed widths of the normalize / square-root datapath of the face normal unit.
// ----------------------------------------------------------------------------
package tfn_pkg;

  // normalized magnitude width, square sum width, root width
  localparam int SCALE_BITS = 31;
  localparam int SUM_BITS   = 64;
  localparam int LEN_BITS   = 32;
  localparam int SQRT_STEPS = 32;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
    logic       last;
  } ctl_t;

  typedef struct packed {
    logic [SUM_BITS-1:0]              v;
    logic [SUM_BITS-1:0]              r;
    logic [2:0][SCALE_BITS-1:0]       s;
    ctl_t                             ctl;
  } sqrt_data_t;

endpackage
`default_nettype wire

@@ sv/tfn_sqrt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_sqrt_cell: one digit of the integer square root
// Resolves one result bit per cell; the remainder and root pass to the next.
// ----------------------------------------------------------------------------
module tfn_sqrt_cell #(
  parameter int STEP = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire tfn_pkg::sqrt_data_t data_i,
  output logic                    valid_o,
  output tfn_pkg::sqrt_data_t     data_o
);

  localparam int SW = tfn_pkg::SUM_BITS;
  localparam logic [SW-1:0] StepBit = SW'(1) << (SW - 2 - 2 * STEP);

  logic [SW:0]         trial;
  tfn_pkg::sqrt_data_t data_d;
  logic                valid_q;
  tfn_pkg::sqrt_data_t data_q;

  always_comb begin
    trial  = {1'b0, data_i.r} + {1'b0, StepBit};
    data_d = data_i;
    if ({1'b0, data_i.v} >= trial) begin
      data_d.v = data_i.v - trial[SW-1:0];
      data_d.r = (data_i.r >> 1) + StepBit;
    end else begin
      data_d.r = data_i.r >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

@@ sv/tfn_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_div_cell: one quotient bit of a restoring divide, three lanes
// Subtracts the shifted divisor when it fits and sets that quotient bit.
// ----------------------------------------------------------------------------
module tfn_div_cell #(
  parameter int DW    = 48,
  parameter int QW    = 15,
  parameter int SHIFT = 0
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [2:0][DW-1:0]          rem_i,
  input  wire logic [tfn_pkg::LEN_BITS:0]  div_i,
  input  wire logic [2:0][QW-1:0]          quo_i,
  input  wire tfn_pkg::ctl_t               ctl_i,
  output logic                             valid_o,
  output logic [2:0][DW-1:0]               rem_o,
  output logic [tfn_pkg::LEN_BITS:0]       div_o,
  output logic [2:0][QW-1:0]               quo_o,
  output tfn_pkg::ctl_t                    ctl_o
);

  localparam int DIVW = tfn_pkg::LEN_BITS + 1;

  logic [DW-1:0]          sub_val;
  logic [2:0][DW-1:0]     rem_d;
  logic [2:0][QW-1:0]     quo_d;
  logic                   valid_q;
  logic [2:0][DW-1:0]     rem_q;
  logic [DIVW-1:0]        div_q;
  logic [2:0][QW-1:0]     quo_q;
  tfn_pkg::ctl_t          ctl_q;

  always_comb begin
    sub_val = {{(DW - DIVW){1'b0}}, div_i} << SHIFT;
    for (int i = 0; i < 3; i++) begin
      rem_d[i] = rem_i[i];
      quo_d[i] = quo_i[i];
      if (rem_i[i] >= sub_val) begin
        rem_d[i]        = rem_i[i] - sub_val;
        quo_d[i][SHIFT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      div_q <= div_i;
      quo_q <= quo_d;
      ctl_q <= ctl_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign div_o   = div_q;
  assign quo_o   = quo_q;
  assign ctl_o   = ctl_q;

endmodule
`default_nettype wire

@@ sv/triangle_face_normal.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Path to result: stages, root chain, divide setup, divide chain, output register.
// Throughput: one triangle per cycle when not stalled; the square root and
// the divide are chains of one-bit cells, each holding one item in flight.
// The whole pipeline advances together; it stalls only while a result waits
// at the output and the downstream side stalls.
// Reset clears all valid flags; the datapath registers are not reset.
// ----------------------------------------------------------------------------
// triangle_face_normal: unit face normal of a triangle
// Edges, exact cross product, normalize to 31 bits, square root, then a
// rounded divide per component into signed Q2.14 (at default width).
// ----------------------------------------------------------------------------
module triangle_face_normal #(
  parameter int COORD_BITS  = 32,
  parameter int NORMAL_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [COORD_BITS-1:0]  ax_i,
  input  wire logic signed [COORD_BITS-1:0]  ay_i,
  input  wire logic signed [COORD_BITS-1:0]  az_i,
  input  wire logic signed [COORD_BITS-1:0]  bx_i,
  input  wire logic signed [COORD_BITS-1:0]  by_i,
  input  wire logic signed [COORD_BITS-1:0]  bz_i,
  input  wire logic signed [COORD_BITS-1:0]  cx_i,
  input  wire logic signed [COORD_BITS-1:0]  cy_i,
  input  wire logic signed [COORD_BITS-1:0]  cz_i,
  input  wire logic                          last_in_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [NORMAL_BITS-1:0]      nx_o,
  output logic signed [NORMAL_BITS-1:0]      ny_o,
  output logic signed [NORMAL_BITS-1:0]      nz_o,
  output logic                               degenerate_o,
  output logic                               last_out_o
);

  // edge, product, cross product and magnitude widths
  localparam int EW  = COORD_BITS + 1;
  localparam int PW  = 2 * EW;
  localparam int NW  = PW + 1;
  localparam int MW  = NW - 1;
  localparam int BLW = $clog2(MW + 1);
  localparam int SB  = tfn_pkg::SCALE_BITS;
  localparam int LB  = tfn_pkg::LEN_BITS;
  localparam int SQW = 2 * SB;
  localparam int SW  = tfn_pkg::SUM_BITS;
  localparam int NST = tfn_pkg::SQRT_STEPS;
  // divide: quotient never exceeds ONE, so NORMAL_BITS-1 bits
  localparam int QW  = NORMAL_BITS - 1;
  localparam int DW  = NORMAL_BITS + 32;
  localparam logic [QW-1:0] One = {1'b1, {(QW - 1){1'b0}}};

  // global advance: move unless a finished result is held up
  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // ---------------- stage 1: edges B-A, C-A ----------------
  logic                        v1_q;
  logic signed [2:0][EW-1:0]   e0_q, e1_q;
  logic                        last1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e0_q[0] <= {bx_i[COORD_BITS-1], bx_i} - {ax_i[COORD_BITS-1], ax_i};
      e0_q[1] <= {by_i[COORD_BITS-1], by_i} - {ay_i[COORD_BITS-1], ay_i};
      e0_q[2] <= {bz_i[COORD_BITS-1], bz_i} - {az_i[COORD_BITS-1], az_i};
      e1_q[0] <= {cx_i[COORD_BITS-1], cx_i} - {ax_i[COORD_BITS-1], ax_i};
      e1_q[1] <= {cy_i[COORD_BITS-1], cy_i} - {ay_i[COORD_BITS-1], ay_i};
      e1_q[2] <= {cz_i[COORD_BITS-1], cz_i} - {az_i[COORD_BITS-1], az_i};
      last1_q <= last_in_i;
    end
  end

  // ---------------- stage 2: edge products for the cross product ----------------
  logic                v2_q;
  logic [5:0][PW-1:0]  p_q;
  logic                last2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0]  <= $signed(e0_q[1]) * $signed(e1_q[2]);
      p_q[1]  <= $signed(e0_q[2]) * $signed(e1_q[1]);
      p_q[2]  <= $signed(e0_q[2]) * $signed(e1_q[0]);
      p_q[3]  <= $signed(e0_q[0]) * $signed(e1_q[2]);
      p_q[4]  <= $signed(e0_q[0]) * $signed(e1_q[1]);
      p_q[5]  <= $signed(e0_q[1]) * $signed(e1_q[0]);
      last2_q <= last1_q;
    end
  end

  // ---------------- stage 3: exact cross product ----------------
  logic                v3_q;
  logic [2:0][NW-1:0]  n_q;
  logic                last3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n_q[i] <= {p_q[2*i][PW-1], p_q[2*i]} - {p_q[2*i+1][PW-1], p_q[2*i+1]};
      end
      last3_q <= last2_q;
    end
  end

  // ---------------- stage 4: sign and magnitude ----------------
  logic                v4_q;
  logic [2:0][MW-1:0]  mag4_q;
  logic [2:0]          neg4_q;
  logic                last4_q;
  logic [2:0][NW-1:0]  n_abs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_abs[i] = n_q[i][NW-1] ? (~n_q[i] + NW'(1)) : n_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag4_q[i] <= n_abs[i][MW-1:0];
        neg4_q[i] <= n_q[i][NW-1];
      end
      last4_q <= last3_q;
    end
  end

  // ---------------- stage 5: largest bit length ----------------
  logic                v5_q;
  logic [2:0][MW-1:0]  mag5_q;
  logic [BLW-1:0]      m5_q;
  tfn_pkg::ctl_t       ctl5_q;
  logic [MW-1:0]       mag_or;
  logic [BLW-1:0]      m_len;

  always_comb begin
    mag_or = mag4_q[0] | mag4_q[1] | mag4_q[2];
    m_len  = '0;
    for (int b = 0; b < MW; b++) begin
      if (mag_or[b]) begin
        m_len = BLW'(b + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag5_q       <= mag4_q;
      m5_q         <= m_len;
      ctl5_q.neg   <= neg4_q;
      ctl5_q.degen <= (mag_or == '0);
      ctl5_q.last  <= last4_q;
    end
  end

  // ---------------- stage 6: scale largest magnitude to 31 bits ----------------
  logic                v6_q;
  logic [2:0][SB-1:0]  s6_q;
  tfn_pkg::ctl_t       ctl6_q;
  logic [2:0][MW-1:0]  shifted;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (m5_q > BLW'(SB)) begin
        shifted[i] = mag5_q[i] >> (m5_q - BLW'(SB));
      end else begin
        shifted[i] = mag5_q[i] << (BLW'(SB) - m5_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s6_q[i] <= shifted[i][SB-1:0];
      end
      ctl6_q <= ctl5_q;
    end
  end

  // ---------------- stage 7: squares ----------------
  logic                v7_q;
  logic [2:0][SB-1:0]  s7_q;
  logic [2:0][SQW-1:0] sq7_q;
  tfn_pkg::ctl_t       ctl7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (en) begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq7_q[i] <= s6_q[i] * s6_q[i];
      end
      s7_q   <= s6_q;
      ctl7_q <= ctl6_q;
    end
  end

  // ---------------- stage 8: sum of squares, root chain entry ----------------
  logic                v8_q;
  tfn_pkg::sqrt_data_t sq_in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else if (en) begin
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_in_q.v   <= SW'(sq7_q[0]) + SW'(sq7_q[1]) + SW'(sq7_q[2]);
      sq_in_q.r   <= '0;
      sq_in_q.s   <= s7_q;
      sq_in_q.ctl <= ctl7_q;
    end
  end

  // ---------------- square-root chain: one root bit per cell ----------------
  logic                sq_valid [NST+1];
  tfn_pkg::sqrt_data_t sq_data  [NST+1];

  assign sq_valid[0] = v8_q;
  assign sq_data[0]  = sq_in_q;

  for (genvar k = 0; k < NST; k++) begin : g_sqrt
    tfn_sqrt_cell #(
      .STEP (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[k]),
      .data_i  (sq_data[k]),
      .valid_o (sq_valid[k+1]),
      .data_o  (sq_data[k+1])
    );
  end

  // ---------------- divide setup: (2*s*ONE + L) over 2L ----------------
  logic                vp_q;
  logic [2:0][DW-1:0]  remp_q;
  logic [LB:0]         divp_q;
  tfn_pkg::ctl_t       ctlp_q;
  logic [LB-1:0]       root_len;

  assign root_len = sq_data[NST].r[LB-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en) begin
      vp_q <= sq_valid[NST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        remp_q[i] <= (DW'(sq_data[NST].s[i]) << (NORMAL_BITS - 1)) + DW'(root_len);
      end
      divp_q <= {root_len, 1'b0};
      ctlp_q <= sq_data[NST].ctl;
    end
  end

  // ---------------- divide chain: one quotient bit per cell ----------------
  logic                dv_valid [QW+1];
  logic [2:0][DW-1:0]  dv_rem   [QW+1];
  logic [LB:0]         dv_div   [QW+1];
  logic [2:0][QW-1:0]  dv_quo   [QW+1];
  tfn_pkg::ctl_t       dv_ctl   [QW+1];

  assign dv_valid[0] = vp_q;
  assign dv_rem[0]   = remp_q;
  assign dv_div[0]   = divp_q;
  assign dv_quo[0]   = '0;
  assign dv_ctl[0]   = ctlp_q;

  for (genvar k = 0; k < QW; k++) begin : g_div
    tfn_div_cell #(
      .DW    (DW),
      .QW    (QW),
      .SHIFT (QW - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_valid[k]),
      .rem_i   (dv_rem[k]),
      .div_i   (dv_div[k]),
      .quo_i   (dv_quo[k]),
      .ctl_i   (dv_ctl[k]),
      .valid_o (dv_valid[k+1]),
      .rem_o   (dv_rem[k+1]),
      .div_o   (dv_div[k+1]),
      .quo_o   (dv_quo[k+1]),
      .ctl_o   (dv_ctl[k+1])
    );
  end

  // ---------------- output register: clamp, sign, degenerate ----------------
  logic                           out_valid_q;
  logic [2:0][NORMAL_BITS-1:0]    n_out_q;
  logic                           degen_q;
  logic                           last_q;
  logic [2:0][NORMAL_BITS-1:0]    n_out_d;
  logic [QW-1:0]                  q_clamp;
  tfn_pkg::ctl_t                  ctl_f;

  assign ctl_f = dv_ctl[QW];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_clamp    = (dv_quo[QW][i] > One) ? One : dv_quo[QW][i];
      n_out_d[i] = ctl_f.neg[i] ? (~{1'b0, q_clamp} + NORMAL_BITS'(1)) : {1'b0, q_clamp};
      if (ctl_f.degen) begin
        n_out_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_out_q <= n_out_d;
      degen_q <= ctl_f.degen;
      last_q  <= ctl_f.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign nx_o         = n_out_q[0];
  assign ny_o         = n_out_q[1];
  assign nz_o         = n_out_q[2];
  assign degenerate_o = degen_q;
  assign last_out_o   = last_q;

endmodule
`default_nettype wire

@@ sv/tfn_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_checker: port-level checks of the face normal unit
// Output hold under stall, stall origin, degenerate and range of the normal.
// ----------------------------------------------------------------------------
module tfn_checker #(
  parameter int COORD_BITS  = 32,
  parameter int NORMAL_BITS = 16
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic signed [NORMAL_BITS-1:0] nx_o,
  input wire logic signed [NORMAL_BITS-1:0] ny_o,
  input wire logic signed [NORMAL_BITS-1:0] nz_o,
  input wire logic                          degenerate_o,
  input wire logic                          last_out_o
);

  localparam logic signed [NORMAL_BITS-1:0] PosOne = NORMAL_BITS'(1) << (NORMAL_BITS - 2);
  localparam logic signed [NORMAL_BITS-1:0] NegOne = -PosOne;

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(nx_o) && $stable(ny_o)
      && $stable(nz_o) && $stable(degenerate_o) && $stable(last_out_o))
    else $error("result changed while stalled");

  // input side backs up only behind a blocked result
  a_stall_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> nx_o == '0 && ny_o == '0 && nz_o == '0)
    else $error("degenerate item with nonzero normal");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> nx_o <= PosOne && nx_o >= NegOne && ny_o <= PosOne
      && ny_o >= NegOne && nz_o <= PosOne && nz_o >= NegOne)
    else $error("normal component beyond one");

endmodule

bind triangle_face_normal tfn_checker #(
  .COORD_BITS  (COORD_BITS),
  .NORMAL_BITS (NORMAL_BITS)
) u_tfn_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .nx_o         (nx_o),
  .ny_o         (ny_o),
  .nz_o         (nz_o),
  .degenerate_o (degenerate_o),
  .last_out_o   (last_out_o)
);
`default_nettype wire
